// ----- design/fixed_slot_pool_allocator_macros.svh -----
// Assertion macros shared by the pool allocator.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define FSPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pool allocator assertion failed");

// Next-cycle implication, disabled in reset.
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pool allocator assertion failed");

`else

`define FSPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/fspa_pkg.sv -----
package fspa_pkg;

  localparam int unsigned IdxFieldW   = 6;
  localparam int unsigned CountFieldW = 7;
  localparam int unsigned StatusW     = 2;

  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_USED = 2'd2;

  localparam logic ACTION_GET    = 1'b0;
  localparam logic ACTION_RETURN = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Memory strobes from the sequencer to the slot store.
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic used_we;
    logic used_wdata;
  } mem_ctrl_t;

  typedef struct packed {
    logic [StatusW-1:0]     status;
    logic [IdxFieldW-1:0]   granted_slot;
    logic [CountFieldW-1:0] free_count;
    logic                   none_in_use;
  } result_t;

endpackage

// ----- design/fspa_store.sv -----
module fspa_store #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk_i,
  input  fspa_pkg::mem_ctrl_t mem_i,
  input  logic [IW-1:0]      link_raddr_i,
  input  logic [IW-1:0]      link_waddr_i,
  input  logic [IW:0]        link_wdata_i,
  output logic [IW:0]        link_rdata_o,
  input  logic [IW-1:0]      used_raddr_i,
  input  logic [IW-1:0]      used_waddr_i,
  output logic               used_rdata_o
);
  import fspa_pkg::*;

  // Next link of each recycled free slot; MSB set means end of list.
  logic [IW:0] link_mem [SLOTS];
  logic        used_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (mem_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (mem_i.rd_en) begin
      link_rdata_o <= link_mem[link_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_i.used_we) begin
      used_mem[used_waddr_i] <= mem_i.used_wdata;
    end
    if (mem_i.rd_en) begin
      used_rdata_o <= used_mem[used_raddr_i];
    end
  end

endmodule

// ----- design/fspa_ctrl.sv -----
`include "fixed_slot_pool_allocator_macros.svh"

module fspa_ctrl #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int unsigned CW    = $clog2(SLOTS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [5:0]          slot_index_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output fspa_pkg::result_t   res_o,
  output fspa_pkg::mem_ctrl_t mem_o,
  output logic [IW-1:0]       link_raddr_o,
  output logic [IW-1:0]       link_waddr_o,
  output logic [IW:0]         link_wdata_o,
  input  logic [IW:0]         link_rdata_i,
  output logic [IW-1:0]       used_raddr_o,
  output logic [IW-1:0]       used_waddr_o,
  input  logic                used_rdata_i
);
  import fspa_pkg::*;

  localparam int unsigned CMPW = (CW > IdxFieldW) ? CW : IdxFieldW;

  state_e         state_q, state_d;
  logic [IW:0]    rec_head_q, rec_head_d;     // head of recycled free slots
  logic [CW-1:0]  fresh_q, fresh_d;           // first slot never handed out
  logic [CW-1:0]  free_total_q, free_total_d;
  logic           action_q;
  logic [5:0]     idx_q;
  logic [IW-1:0]  idx_addr;
  logic [IW-1:0]  grant_addr;
  logic           in_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rec_head_q   <= {1'b1, {IW{1'b0}}};
      fresh_q      <= '0;
      free_total_q <= CW'(SLOTS);
    end else begin
      state_q      <= state_d;
      rec_head_q   <= rec_head_d;
      fresh_q      <= fresh_d;
      free_total_q <= free_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && state_q == ST_IDLE) begin
      action_q <= action_i;
      idx_q    <= slot_index_i;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign res_valid_o  = (state_q == ST_EXEC);
  assign idx_addr     = IW'({{IW{1'b0}}, idx_q});
  assign link_raddr_o = rec_head_q[IW-1:0];
  assign used_raddr_o = IW'({{IW{1'b0}}, slot_index_i});
  assign link_waddr_o = idx_addr;
  assign link_wdata_o = rec_head_q;
  assign grant_addr   = rec_head_q[IW] ? fresh_q[IW-1:0] : rec_head_q[IW-1:0];
  // Slots at or past the fresh pointer were never granted, so never in use.
  assign in_use       = (CMPW'(idx_q) < CMPW'(fresh_q)) && used_rdata_i;

  always_comb begin
    state_d      = state_q;
    rec_head_d   = rec_head_q;
    fresh_d      = fresh_q;
    free_total_d = free_total_q;
    mem_o        = '0;
    used_waddr_o = idx_addr;
    res_o.status = STATUS_OK;
    res_o.granted_slot = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_o.rd_en = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (action_q == ACTION_GET) begin
          if (!rec_head_q[IW] || (fresh_q < CW'(SLOTS))) begin
            res_o.granted_slot = IdxFieldW'(grant_addr);
            used_waddr_o       = grant_addr;
            mem_o.used_wdata   = 1'b1;
            if (res_ready_i) begin
              mem_o.used_we = 1'b1;
              free_total_d  = free_total_q - CW'(1);
              if (rec_head_q[IW]) begin
                fresh_d = fresh_q + CW'(1);
              end else begin
                rec_head_d = link_rdata_i;
              end
            end
          end else begin
            res_o.status = STATUS_EMPTY;
          end
        end else begin
          if (in_use) begin
            if (res_ready_i) begin
              mem_o.link_we = 1'b1;
              mem_o.used_we = 1'b1;
              rec_head_d    = {1'b0, idx_addr};
              free_total_d  = free_total_q + CW'(1);
            end
          end else begin
            res_o.status = STATUS_NOT_USED;
          end
        end
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    res_o.free_count  = CountFieldW'(free_total_d);
    res_o.none_in_use = (free_total_d == CW'(SLOTS));
  end

  `FSPA_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, free_total_q <= CW'(SLOTS))
  `FSPA_ASSERT_IMPLY(a_recycled_counted, clk_i, rst_ni, !rec_head_q[IW],
                     ({1'b0, free_total_q} + {1'b0, fresh_q}) > (CW+1)'(SLOTS))
  `FSPA_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, state_q == ST_IDLE && in_valid_i,
                    state_q == ST_EXEC)
  `FSPA_ASSERT_NEXT(a_exec_done, clk_i, rst_ni, state_q == ST_EXEC && res_ready_i,
                    state_q == ST_IDLE)

endmodule

// ----- design/fixed_slot_pool_allocator.sv -----
// Fixed-slot pool allocator: hands out and takes back slot indices of a pool of
// SLOTS slots. A get beat (action 0) pops the most recently returned free slot,
// or, if none was returned, the lowest slot never handed out, so that after reset
// slots come out 0, 1, 2 and so on; an empty pool answers status 1. A return beat
// (action 1) frees slot_index if it is in use, else answers status 2 and changes
// nothing. Every beat yields exactly one result beat with the free count and
// whether no slot is in use. An item is a single read-modify-write pass through the
// link and in-use memories: the idle state accepts it and starts their synchronous
// reads, then the exec state updates them and loads the output register. A stalled
// output holds the exec state only while the output register is still full, and no
// new beat is accepted before exec ends. No clearing pass runs after reset: a
// fresh-slot pointer marks the part of the pool that was never touched.
module fixed_slot_pool_allocator #(
  parameter int unsigned SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [5:0] slot_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [5:0] granted_slot_o,
  output logic [6:0] free_count_o,
  output logic       none_in_use_o
);
  import fspa_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  mem_ctrl_t     mem;
  result_t       res, out_q;
  logic          res_valid, res_ready;
  logic          out_valid_q;
  logic [IW-1:0] link_raddr, link_waddr, used_raddr, used_waddr;
  logic [IW:0]   link_wdata, link_rdata;
  logic          used_rdata;

  // The output register is free when empty or when its beat leaves now.
  assign res_ready = !out_valid_q || !out_stall_i;

  fspa_ctrl #(
    .SLOTS(SLOTS),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .slot_index_i(slot_index_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem),
    .link_raddr_o(link_raddr),
    .link_waddr_o(link_waddr),
    .link_wdata_o(link_wdata),
    .link_rdata_i(link_rdata),
    .used_raddr_o(used_raddr),
    .used_waddr_o(used_waddr),
    .used_rdata_i(used_rdata)
  );

  fspa_store #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_store (
    .clk_i       (clk_i),
    .mem_i       (mem),
    .link_raddr_i(link_raddr),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata),
    .link_rdata_o(link_rdata),
    .used_raddr_i(used_raddr),
    .used_waddr_i(used_waddr),
    .used_rdata_o(used_rdata)
  );

  // Output register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign granted_slot_o = out_q.granted_slot;
  assign free_count_o   = out_q.free_count;
  assign none_in_use_o  = out_q.none_in_use;

endmodule
